### rtl/lst_pkg.sv
// Package for the location set table: sizes, key layout, operation and status codes.
// Used by the request/response interfaces and by location_set_table.
// No dependencies.
package lst_pkg;

	// Number of key slots in the table.
	localparam int DEPTH = 16;

	// Slot index width and count width (the count must hold DEPTH itself).
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Key layout: file tag in the upper bits, line number in the lower bits.
	localparam int TAG_W  = 16;
	localparam int LINE_W = 20;
	localparam int KEY_W  = TAG_W + LINE_W;

	// Summary mask: one bit per value of the low line-number bits.
	localparam int MASK_W     = 32;
	localparam int LINE_SEL_W = $clog2(MASK_W);

	// Response field widths.
	localparam int FIDX_W  = 4;
	localparam int ENTRY_W = 5;

	typedef logic [1:0]          kind_t;
	typedef logic [1:0]          status_t;
	typedef logic [TAG_W-1:0]    tag_t;
	typedef logic [LINE_W-1:0]   line_t;
	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [MASK_W-1:0]   mask_t;
	typedef logic [FIDX_W-1:0]   fidx_t;
	typedef logic [ENTRY_W-1:0]  entry_t;

	// Operation codes.
	localparam kind_t KIND_INSERT = 2'd0;
	localparam kind_t KIND_REMOVE = 2'd1;
	localparam kind_t KIND_FIND   = 2'd2;

	// Status codes.
	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_DUP      = 2'd1;
	localparam status_t STATUS_FULL     = 2'd2;
	localparam status_t STATUS_NOTFOUND = 2'd3;

endpackage

### rtl/lst_req_if.sv
// Request channel of the location set table: valid/ready plus the key operation.
// Depends on lst_pkg.
interface lst_req_if;
	logic            valid;
	logic            ready;
	lst_pkg::kind_t  kind;
	lst_pkg::tag_t   file_tag;
	lst_pkg::line_t  line_number;

	modport source (output valid, kind, file_tag, line_number, input ready);
	modport sink (input valid, kind, file_tag, line_number, output ready);
endinterface

### rtl/lst_rsp_if.sv
// Response channel of the location set table: valid/ready plus the result fields.
// Depends on lst_pkg.
interface lst_rsp_if;
	logic              valid;
	logic              ready;
	lst_pkg::status_t  status;
	logic              found;
	lst_pkg::fidx_t    found_index;
	lst_pkg::entry_t   entry_count;
	lst_pkg::mask_t    summary_mask;

	modport source (output valid, status, found, found_index, entry_count, summary_mask,
		input ready);
	modport sink (input valid, status, found, found_index, entry_count, summary_mask,
		output ready);
endinterface

### rtl/location_set_table.sv
// Location set table top level. Depends on lst_pkg, lst_req_if and lst_rsp_if.
// Holds up to DEPTH packed keys in a single-port synchronous key memory.
//
// The table takes one request transaction at a time and returns exactly one response
// transaction for it. All work goes through the key memory, which gives one read per
// cycle from a registered read port; each step of a scan is a read state followed by
// a state that uses the read data. An insert into a full table and an unused operation
// code go straight to the completion state; find and insert scan the stored keys until
// a match or the end; a remove of a stored key searches for it, shifts the later keys
// down and rebuilds the summary mask; a remove of a missing key scans every stored key.
// A result that finds the output register still occupied waits in the completion state
// until the register is read, and the next request is taken while the previous result
// still waits in the output register.
module location_set_table (
	input  logic        clk,
	input  logic        arst_n,
	lst_req_if.sink     req,
	lst_rsp_if.source   rsp
);
	import lst_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_MASK_RD,
		S_MASK_ACC,
		S_DONE
	} state_t;

	state_t               state_q;
	kind_t                op_q;
	key_t                 key_q;
	logic [CNT_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     count_q;
	mask_t                mask_q;
	mask_t                acc_q;
	status_t              status_q;
	logic                 found_q;
	logic [CNT_W-1:0]     fidx_q;
	logic                 rsp_valid_q;

	key_t                 mem [DEPTH];
	key_t                 rd_data_q;
	logic [IDX_W-1:0]     rd_addr;
	logic [IDX_W-1:0]     wr_addr;
	key_t                 wr_data;
	logic                 mem_we;
	logic [CNT_W-1:0]     ptr_inc;
	mask_t                rd_line_bit;

	assign ptr_inc     = ptr_q + CNT_W'(1);
	assign rd_line_bit = MASK_W'(1) << rd_data_q[LINE_SEL_W-1:0];
	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = rsp_valid_q;

	// Memory port control: addresses and write enable follow the sequencer state.
	always_comb begin
		mem_we  = 1'b0;
		rd_addr = ptr_q[IDX_W-1:0];
		wr_addr = ptr_q[IDX_W-1:0];
		wr_data = rd_data_q;
		unique case (state_q)
			S_SRCH_RD: begin
				// End of search for an insert: append the new key.
				if (ptr_q == count_q && op_q == KIND_INSERT) begin
					mem_we  = 1'b1;
					wr_addr = count_q[IDX_W-1:0];
					wr_data = key_q;
				end
			end
			S_SHIFT_RD: begin
				rd_addr = ptr_inc[IDX_W-1:0];
			end
			S_SHIFT_WR: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Key memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Sequencer, table state and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			mask_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// A response transaction empties the output register unless a new result
			// moves in at the same edge.
			if (rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q     <= req.kind;
						key_q    <= {req.file_tag, req.line_number};
						ptr_q    <= '0;
						status_q <= STATUS_OK;
						found_q  <= 1'b0;
						fidx_q   <= '0;
						if (req.kind == KIND_INSERT) begin
							if (count_q >= CNT_W'(DEPTH)) begin
								status_q <= STATUS_FULL;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_SRCH_RD;
							end
						end else if (req.kind == KIND_REMOVE || req.kind == KIND_FIND) begin
							state_q <= S_SRCH_RD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SRCH_RD: begin
					if (ptr_q == count_q) begin
						// Scanned every stored key without a match.
						if (op_q == KIND_INSERT) begin
							count_q <= count_q + CNT_W'(1);
							mask_q  <= mask_q | (MASK_W'(1) << key_q[LINE_SEL_W-1:0]);
						end else begin
							status_q <= STATUS_NOTFOUND;
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_SRCH_CMP;
					end
				end
				S_SRCH_CMP: begin
					if (rd_data_q == key_q) begin
						if (op_q == KIND_INSERT) begin
							status_q <= STATUS_DUP;
							state_q  <= S_DONE;
						end else if (op_q == KIND_REMOVE) begin
							state_q <= S_SHIFT_RD;
						end else begin
							found_q <= 1'b1;
							fidx_q  <= ptr_q;
							state_q <= S_DONE;
						end
					end else begin
						ptr_q   <= ptr_inc;
						state_q <= S_SRCH_RD;
					end
				end
				S_SHIFT_RD: begin
					// Close the gap one slot at a time, then rebuild the mask.
					if (ptr_inc == count_q) begin
						count_q <= count_q - CNT_W'(1);
						ptr_q   <= '0;
						acc_q   <= '0;
						state_q <= S_MASK_RD;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					ptr_q   <= ptr_inc;
					state_q <= S_SHIFT_RD;
				end
				S_MASK_RD: begin
					if (ptr_q == count_q) begin
						mask_q  <= acc_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_MASK_ACC;
					end
				end
				S_MASK_ACC: begin
					acc_q   <= acc_q | rd_line_bit;
					ptr_q   <= ptr_inc;
					state_q <= S_MASK_RD;
				end
				S_DONE: begin
					// Move the result out once the output register is free.
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q      <= 1'b1;
						rsp.status       <= status_q;
						rsp.found        <= found_q;
						rsp.found_index  <= FIDX_W'(fidx_q);
						rsp.entry_count  <= ENTRY_W'(count_q);
						rsp.summary_mask <= mask_q;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The stored count never exceeds the table size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("stored count exceeds table size");

	// The count moves by at most one per cycle.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
		(count_q == $past(count_q) + CNT_W'(1) || count_q == $past(count_q) - CNT_W'(1)))
		else $error("stored count jumped");

	// Writes only land inside the packed region or on the slot just past it.
	a_write_slot: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> CNT_W'(wr_addr) <= count_q)
		else $error("key memory write outside packed region");

	// A new response only comes from the completion state.
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !$past(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("response raised outside completion");

	// A full refusal is only reported when the table is full.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp.status == STATUS_FULL |-> rsp.entry_count == ENTRY_W'(DEPTH))
		else $error("full status with free slots");

endmodule

### test/location_set_table_tb.sv
`timescale 1ns / 100ps
// Testbench for location_set_table: insert, remove and find transactions against
// a shadow copy of the key table, with random idling and a long response hold-off.
// Depends on lst_pkg, lst_req_if, lst_rsp_if and the location_set_table RTL.
module location_set_table_tb;
	import lst_pkg::*;

	localparam kind_t KIND_UNUSED  = 2'd3;
	localparam int    QUIET_LIMIT  = 4000;
	localparam int    HOLD_CYCLES  = 400;
	localparam int    RANDOM_ITEMS = 1400;
	localparam int    POOL_SIZE    = 20;
	localparam int    REPORT_MAX   = 10;

	typedef struct packed {
		status_t status;
		logic    found;
		fidx_t   found_index;
		entry_t  entry_count;
		mask_t   summary_mask;
	} table_result_t;

	logic clk;
	logic arst_n;

	lst_req_if req();
	lst_rsp_if rsp();

	location_set_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Shadow of the table contents, updated when a request transaction is accepted.
	key_t          shadow_keys [DEPTH];
	int            shadow_count;
	table_result_t pending_results [$];
	key_t          key_pool [POOL_SIZE];

	bit req_idle;
	bit rsp_idle;
	int hold_left;
	int mismatches;
	int quiet_cycles;
	int kind_sent [4];
	int status_seen [4];

	// 12 ns clock.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// First slot holding the key, or -1 when it is absent.
	function automatic int locate_key(key_t key);
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_keys[i] == key)
				return i;
		end
		return -1;
	endfunction

	// One mask bit per value of the low line-number bits of the stored keys.
	function automatic mask_t line_summary();
		mask_t m;
		m = '0;
		for (int i = 0; i < shadow_count; i++)
			m[shadow_keys[i][LINE_SEL_W-1:0]] = 1'b1;
		return m;
	endfunction

	// Applies one operation to the shadow table and returns the response it must produce.
	function automatic table_result_t apply_op(kind_t kind, key_t key);
		table_result_t r;
		int pos;
		r = '0;
		r.status = STATUS_OK;
		pos = locate_key(key);
		case (kind)
			KIND_INSERT: begin
				if (shadow_count >= DEPTH) begin
					r.status = STATUS_FULL;
				end else if (pos >= 0) begin
					r.status = STATUS_DUP;
				end else begin
					shadow_keys[shadow_count] = key;
					shadow_count++;
				end
			end
			KIND_REMOVE: begin
				if (pos < 0) begin
					r.status = STATUS_NOTFOUND;
				end else begin
					for (int i = pos; i < shadow_count - 1; i++)
						shadow_keys[i] = shadow_keys[i + 1];
					shadow_count--;
				end
			end
			KIND_FIND: begin
				if (pos < 0) begin
					r.status = STATUS_NOTFOUND;
				end else begin
					r.found = 1'b1;
					r.found_index = fidx_t'(pos);
				end
			end
			default: begin
			end
		endcase
		r.entry_count = entry_t'(shadow_count);
		r.summary_mask = line_summary();
		return r;
	endfunction

	function automatic key_t random_key();
		return key_t'({$urandom, $urandom});
	endfunction

	// Nearly half the keys are stored or close to stored ones, so hits, duplicates and
	// near misses are common; the rest come from a pool or are fully random.
	function automatic key_t pick_key();
		int roll;
		key_t k;
		roll = $urandom_range(0, 99);
		if (shadow_count > 0 && roll < 45) begin
			k = shadow_keys[$urandom_range(0, shadow_count - 1)];
			if (roll >= 35)
				k = k ^ (key_t'(1) << $urandom_range(0, KEY_W - 1));
			return k;
		end
		if (roll < 85)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return random_key();
	endfunction

	// Offers one request transaction and waits until it is accepted.
	task automatic send_op(kind_t kind, key_t key);
		while (req_idle && $urandom_range(0, 99) < 20) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid       <= 1'b1;
		req.kind        <= kind;
		req.file_tag    <= key[KEY_W-1:LINE_W];
		req.line_number <= key[LINE_W-1:0];
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		pending_results.push_back(apply_op(kind, key));
		kind_sent[kind]++;
	endtask

	// Stops offering and waits for every outstanding response.
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, name, want,
					got);
		end
	endtask

	// Empty table, key extremes, duplicates, misses, the unused code and shifting removes.
	task automatic test_empty_table();
		key_t k_ones;
		key_t k_mid;
		k_ones = '1;
		k_mid = {16'h8000, 20'h0001F};
		send_op(KIND_FIND, '0);
		send_op(KIND_REMOVE, '0);
		send_op(KIND_UNUSED, k_ones);
		send_op(KIND_INSERT, '0);
		send_op(KIND_INSERT, k_ones);
		send_op(KIND_INSERT, k_ones);
		send_op(KIND_INSERT, k_mid);
		send_op(KIND_INSERT, {16'h0001, 20'h80000});
		send_op(KIND_FIND, '0);
		send_op(KIND_FIND, k_ones);
		send_op(KIND_FIND, k_mid);
		send_op(KIND_FIND, k_ones ^ key_t'(1));
		send_op(KIND_REMOVE, {16'h8001, 20'h0001F});
		send_op(KIND_UNUSED, '0);
		send_op(KIND_REMOVE, '0);
		send_op(KIND_FIND, k_ones);
		send_op(KIND_REMOVE, k_mid);
		send_op(KIND_REMOVE, k_ones);
		send_op(KIND_REMOVE, {16'h0001, 20'h80000});
		send_op(KIND_FIND, k_ones);
		drain();
	endtask

	// Fill to capacity: full refusal wins over duplicate, then removes in the middle and at both ends.
	task automatic test_full_table();
		key_t first_key;
		while (shadow_count < DEPTH)
			send_op(KIND_INSERT, random_key());
		first_key = shadow_keys[0];
		send_op(KIND_INSERT, random_key());
		send_op(KIND_INSERT, shadow_keys[3]);
		send_op(KIND_FIND, shadow_keys[DEPTH - 1]);
		send_op(KIND_REMOVE, shadow_keys[7]);
		send_op(KIND_REMOVE, shadow_keys[shadow_count - 1]);
		send_op(KIND_REMOVE, first_key);
		send_op(KIND_FIND, first_key);
		send_op(KIND_FIND, shadow_keys[0]);
		send_op(KIND_INSERT, first_key);
		send_op(KIND_FIND, first_key);
		drain();
	endtask

	// Responses are held off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		req_idle = 1'b0;
		hold_left = HOLD_CYCLES;
		repeat (24)
			send_op(kind_t'($urandom_range(KIND_INSERT, KIND_FIND)), pick_key());
		drain();
		req_idle = 1'b1;
	endtask

	// Random mix in phases that alternately fill and drain the table.
	task automatic test_random_mix();
		int roll;
		bit fill_phase;
		kind_t kind;
		fill_phase = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 250 == 0) begin
				foreach (key_pool[i])
					key_pool[i] = random_key();
			end
			if (n % 100 == 0)
				fill_phase = !fill_phase;
			req_idle = !(n >= 500 && n < 800);
			rsp_idle = req_idle;
			roll = $urandom_range(0, 99);
			if (roll < (fill_phase ? 50 : 25))
				kind = KIND_INSERT;
			else if (roll < (fill_phase ? 65 : 60))
				kind = KIND_REMOVE;
			else if (roll < 95)
				kind = KIND_FIND;
			else
				kind = KIND_UNUSED;
			send_op(kind, pick_key());
		end
		drain();
	endtask

	// Response side: random stalls, the long hold-off, and the check of each transaction.
	always @(posedge clk) begin
		table_result_t want;
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= !(rsp_idle && $urandom_range(0, 99) < 20);
		end
		if (rsp.valid && rsp.ready) begin
			if (rsp.status !== 2'bxx && !$isunknown(rsp.status))
				status_seen[rsp.status]++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: response with no request outstanding", $realtime);
			end else begin
				want = pending_results.pop_front();
				compare_field("status", 32'(want.status), 32'(rsp.status));
				compare_field("found", 32'(want.found), 32'(rsp.found));
				compare_field("found_index", 32'(want.found_index), 32'(rsp.found_index));
				compare_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
				compare_field("summary_mask", want.summary_mask, rsp.summary_mask);
			end
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		req.valid = 1'b0;
		req.kind = KIND_INSERT;
		req.file_tag = '0;
		req.line_number = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		shadow_count = 0;
		req_idle = 1'b1;
		rsp_idle = 1'b1;
		hold_left = 0;
		mismatches = 0;
		quiet_cycles = 0;
		foreach (kind_sent[i])
			kind_sent[i] = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		foreach (key_pool[i])
			key_pool[i] = random_key();

		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_full_table();
		test_backpressure();
		test_random_mix();

		// Let any stray response show up before the verdict.
		repeat (200)
			@(posedge clk);

		$display("Sent %0d inserts, %0d removes, %0d finds, %0d unused-code requests.",
			kind_sent[KIND_INSERT], kind_sent[KIND_REMOVE], kind_sent[KIND_FIND],
			kind_sent[KIND_UNUSED]);
		$display("Saw %0d ok, %0d duplicate, %0d full, %0d not-found responses.",
			status_seen[STATUS_OK], status_seen[STATUS_DUP], status_seen[STATUS_FULL],
			status_seen[STATUS_NOTFOUND]);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d responses missing", mismatches,
				pending_results.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
